### sv/bersdf_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and decade threshold tables for the ber degrade/fail monitor
// no dependencies

package bersdf_pkg;

  localparam int unsigned CNT_W     = 48;  // error count and microsecond time
  localparam int unsigned RATE_W    = 58;  // errors per second
  localparam int unsigned LVL_W     = 4;   // indicator register width
  localparam int unsigned THR_W     = 32;  // widest decade threshold
  localparam int unsigned DIV_STEPS = RATE_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // elapsed us to whole ms: split at 2^24 = 16777 * 1000 + 216, so
  // us / 1000 = hi * 16777 + (hi * 216 + lo) / 1000 with the last part below 2^32;
  // that part is divided by 8 and then by 125 through a reciprocal multiply
  localparam int unsigned MS_SPLIT_W  = 24;
  localparam int unsigned MS_HI_MUL   = 16777;
  localparam int unsigned MS_LO_MUL   = 216;
  localparam int unsigned MS_N_W      = 32;
  localparam int unsigned MS_PRE_SH   = 3;           // divide by 8 first
  localparam int unsigned MS_RECIP    = 549755814;   // ceil(2^36 / 125)
  localparam int unsigned MS_RECIP_SH = 36;
  localparam int unsigned MS_PROD_W   = 59;          // 29-bit value by 30-bit reciprocal
  localparam int unsigned MS_LO_W     = MS_PROD_W - MS_RECIP_SH;

  // configuration register indexes
  typedef enum logic {
    REG_SD_LEVEL = 1'b0,
    REG_SF_LEVEL = 1'b1
  } cfg_reg_e;

  // classification of a rate against one threshold
  typedef enum logic [1:0] {
    LVL_OVER  = 2'd0,
    LVL_UNDER = 2'd1,
    LVL_CLEAR = 2'd2
  } lvl_state_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MS_SPLIT,
    ST_MS_MUL,
    ST_MS_SUM,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] quotient;
  } div_rsp_t;

  // decade threshold, indicators above ten act as five
  function automatic logic [THR_W-1:0] level_thr(input logic [LVL_W-1:0] level);
    logic [THR_W-1:0] thr;
    unique case (level)
      4'd0:    thr = 32'd2488320000;
      4'd1:    thr = 32'd248832000;
      4'd2:    thr = 32'd24883200;
      4'd3:    thr = 32'd2488320;
      4'd4:    thr = 32'd248832;
      4'd5:    thr = 32'd24883;
      4'd6:    thr = 32'd2488;
      4'd7:    thr = 32'd248;
      4'd8:    thr = 32'd24;
      4'd9:    thr = 32'd2;
      4'd10:   thr = 32'd1;
      default: thr = 32'd24883;
    endcase
    return thr;
  endfunction

  // threshold / 10, truncated
  function automatic logic [THR_W-1:0] level_clr(input logic [LVL_W-1:0] level);
    logic [THR_W-1:0] clr;
    unique case (level)
      4'd0:    clr = 32'd248832000;
      4'd1:    clr = 32'd24883200;
      4'd2:    clr = 32'd2488320;
      4'd3:    clr = 32'd248832;
      4'd4:    clr = 32'd24883;
      4'd5:    clr = 32'd2488;
      4'd6:    clr = 32'd248;
      4'd7:    clr = 32'd24;
      4'd8:    clr = 32'd2;
      4'd9:    clr = 32'd0;
      4'd10:   clr = 32'd0;
      default: clr = 32'd2488;
    endcase
    return clr;
  endfunction

endpackage

### sv/bersdf_div.sv
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on bersdf_pkg

module bersdf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bersdf_pkg::div_req_t req_i,
  output bersdf_pkg::div_rsp_t rsp_o
);

  logic [bersdf_pkg::RATE_W-1:0] dvd_q, dvd_d;
  logic [bersdf_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic [bersdf_pkg::CNT_W-1:0]  dsr_q, dsr_d;
  logic [bersdf_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [bersdf_pkg::CNT_W:0]    shifted;
  logic [bersdf_pkg::CNT_W:0]    trial;
  logic                          fits;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  assign shifted = {rem_q, dvd_q[bersdf_pkg::RATE_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = (shifted >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = bersdf_pkg::STEP_W'(bersdf_pkg::DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[bersdf_pkg::RATE_W-2:0], fits};
      rem_d = fits ? trial[bersdf_pkg::CNT_W-1:0] : shifted[bersdf_pkg::CNT_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !req_i.start) |=> done_q)
    else $error("divider missed its done pulse");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (dsr_q != '0))
    else $error("divider running with zero divisor");
`endif

endmodule

### sv/bersdf_class.sv
`timescale 1ns / 1ps
// classes a rate against one decade threshold: over, under or under and clear
// depends on bersdf_pkg

module bersdf_class (
  input  logic [bersdf_pkg::RATE_W-1:0] rate_i,
  input  logic [bersdf_pkg::LVL_W-1:0]  level_i,
  output bersdf_pkg::lvl_state_e        state_o
);

  logic [bersdf_pkg::RATE_W-1:0] thr;
  logic [bersdf_pkg::RATE_W-1:0] clr;

  assign thr = {{(bersdf_pkg::RATE_W - bersdf_pkg::THR_W){1'b0}},
                bersdf_pkg::level_thr(level_i)};
  assign clr = {{(bersdf_pkg::RATE_W - bersdf_pkg::THR_W){1'b0}},
                bersdf_pkg::level_clr(level_i)};

  always_comb begin
    priority if (rate_i > thr) begin
      state_o = bersdf_pkg::LVL_OVER;
    end else if (rate_i <= clr) begin
      state_o = bersdf_pkg::LVL_CLEAR;
    end else begin
      state_o = bersdf_pkg::LVL_UNDER;
    end
  end

endmodule

### sv/ber_signal_degrade_fail_monitor_unit.sv
`timescale 1ns / 1ps
// ber signal degrade / signal fail monitor, top level
// depends on bersdf_pkg, bersdf_div, bersdf_class
//
// usage
//   input channel: one beat carries a cumulative bip error count and the uptime
//   in microseconds; a beat is taken when in_valid_i is high and in_stall_o low
//   output channel: one beat per input beat with the errors per second and the
//   degrade and fail classes (0 over, 1 under, 2 under and clear)
//   config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 degrade indicator, 1 fail indicator); write only while the block is idle
// timing
//   in_stall_o is high from a beat until the sequencer is back in idle: elapsed us
//   turns into whole ms (split, reciprocal multiply, sum), the shared 58-step
//   divider starts on errors*1000 / ms and takes 58 steps, its done pulse and an
//   output load follow; a new beat waits until the last one is through
//   the result sits in an output register, so a new beat is taken while an older
//   result still waits; a stalled receiver holds the sequencer in its final
//   state until the output register frees
// reset
//   previous count and time clear to zero, indicators go to 9 and 5

module ber_signal_degrade_fail_monitor_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bersdf_pkg::LVL_W-1:0]   cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bersdf_pkg::CNT_W-1:0]   err_count_i,
  input  logic [bersdf_pkg::CNT_W-1:0]   now_us_i,
  // output beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bersdf_pkg::RATE_W-1:0]  err_rate_o,
  output logic [1:0]                     degrade_cls_o,
  output logic [1:0]                     fail_cls_o
);

  bersdf_pkg::seq_state_e state_q, state_d;

  // indicator registers
  logic [bersdf_pkg::LVL_W-1:0] sd_level_q;
  logic [bersdf_pkg::LVL_W-1:0] sf_level_q;

  // previous sample
  logic [bersdf_pkg::CNT_W-1:0] last_count_q;
  logic [bersdf_pkg::CNT_W-1:0] last_time_q;

  // working registers
  logic [bersdf_pkg::CNT_W-1:0]   diff_q;
  logic [bersdf_pkg::CNT_W-1:0]   el_us_q;
  logic [bersdf_pkg::RATE_W-1:0]  prod_q;
  logic [bersdf_pkg::MS_N_W-1:0]  ms_n_q;
  logic [bersdf_pkg::CNT_W-1:0]   ms_hi_q;
  logic [bersdf_pkg::MS_LO_W-1:0] ms_lo_q;
  logic [bersdf_pkg::CNT_W-1:0]   ms_q;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [bersdf_pkg::RATE_W-1:0]  rate_q;
  bersdf_pkg::lvl_state_e         sd_q;
  bersdf_pkg::lvl_state_e         sf_q;

  logic                             in_beat;
  logic                             out_beat;
  logic                             out_load;
  logic [bersdf_pkg::CNT_W-1:0]     diff_new;
  logic [bersdf_pkg::RATE_W-1:0]    prod_new;
  logic [bersdf_pkg::MS_N_W-1:0]    ms_n_new;
  logic [bersdf_pkg::CNT_W-1:0]     ms_hi_new;
  logic [bersdf_pkg::MS_PROD_W-1:0] ms_recip;
  bersdf_pkg::lvl_state_e           sd_new;
  bersdf_pkg::lvl_state_e           sf_new;

  bersdf_pkg::div_req_t div_req;
  bersdf_pkg::div_rsp_t div_rsp;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_q && !out_stall_i;

  // counter going down means it was reset, the new count is the count itself
  assign diff_new = (err_count_i >= last_count_q) ? (err_count_i - last_count_q)
                                                  : err_count_i;

  // diff * 1000 as 1024 - 16 - 8
  assign prod_new = {diff_q, 10'd0}
                  - {6'd0, diff_q, 4'd0}
                  - {7'd0, diff_q, 3'd0};

  // elapsed us split at 2^24: low part plus 216 per unit of the high part
  assign ms_n_new =
      bersdf_pkg::MS_N_W'(el_us_q[bersdf_pkg::CNT_W-1:bersdf_pkg::MS_SPLIT_W])
    * bersdf_pkg::MS_N_W'(bersdf_pkg::MS_LO_MUL)
    + bersdf_pkg::MS_N_W'(el_us_q[bersdf_pkg::MS_SPLIT_W-1:0]);

  // 16777 whole ms per unit of the high part, a 24 by 15 bit constant product
  assign ms_hi_new =
      bersdf_pkg::CNT_W'(el_us_q[bersdf_pkg::CNT_W-1:bersdf_pkg::MS_SPLIT_W])
    * bersdf_pkg::CNT_W'(bersdf_pkg::MS_HI_MUL);

  // (n / 8) / 125 by reciprocal, exact for n below 2^32
  assign ms_recip =
      bersdf_pkg::MS_PROD_W'(ms_n_q[bersdf_pkg::MS_N_W-1:bersdf_pkg::MS_PRE_SH])
    * bersdf_pkg::MS_PROD_W'(bersdf_pkg::MS_RECIP);

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_level_q <= bersdf_pkg::LVL_W'(9);
      sf_level_q <= bersdf_pkg::LVL_W'(5);
    end else if (cfg_we_i) begin
      unique case (bersdf_pkg::cfg_reg_e'(cfg_idx_i))
        bersdf_pkg::REG_SD_LEVEL: sd_level_q <= cfg_data_i;
        bersdf_pkg::REG_SF_LEVEL: sf_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bersdf_pkg::ST_IDLE:      if (in_beat) state_d = bersdf_pkg::ST_MS_SPLIT;
      bersdf_pkg::ST_MS_SPLIT:  state_d = bersdf_pkg::ST_MS_MUL;
      bersdf_pkg::ST_MS_MUL:    state_d = bersdf_pkg::ST_MS_SUM;
      bersdf_pkg::ST_MS_SUM:    state_d = bersdf_pkg::ST_RATE_GO;
      bersdf_pkg::ST_RATE_GO:   state_d = bersdf_pkg::ST_RATE_WAIT;
      bersdf_pkg::ST_RATE_WAIT: if (div_rsp.done) state_d = bersdf_pkg::ST_DONE;
      bersdf_pkg::ST_DONE:      if (!out_valid_q || !out_stall_i) begin
        state_d = bersdf_pkg::ST_IDLE;
      end
      default:                  state_d = bersdf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall_o       = 1'b1;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = bersdf_pkg::CNT_W'(1);
    unique case (state_q)
      bersdf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      bersdf_pkg::ST_RATE_GO: begin
        // less than one millisecond counts as one
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = (ms_q == '0) ? bersdf_pkg::CNT_W'(1) : ms_q;
      end
      bersdf_pkg::ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bersdf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // previous sample, taken on each input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      last_time_q  <= '0;
    end else if (in_beat) begin
      last_count_q <= err_count_i;
      last_time_q  <= now_us_i;
    end
  end

  // working data, elapsed time wraps modulo 2^48
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      diff_q  <= diff_new;
      el_us_q <= now_us_i - last_time_q;
    end
    if (state_q == bersdf_pkg::ST_MS_SPLIT) begin
      prod_q  <= prod_new;
      ms_n_q  <= ms_n_new;
      ms_hi_q <= ms_hi_new;
    end
    if (state_q == bersdf_pkg::ST_MS_MUL) begin
      ms_lo_q <= ms_recip[bersdf_pkg::MS_PROD_W-1:bersdf_pkg::MS_RECIP_SH];
    end
    if (state_q == bersdf_pkg::ST_MS_SUM) begin
      ms_q <= ms_hi_q + bersdf_pkg::CNT_W'(ms_lo_q);
    end
  end

  // ---------------------------------------------------------------------------
  // shared divider and threshold classing
  // ---------------------------------------------------------------------------
  bersdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bersdf_class u_sd_class (
    .rate_i  (div_rsp.quotient),
    .level_i (sd_level_q),
    .state_o (sd_new)
  );

  bersdf_class u_sf_class (
    .rate_i  (div_rsp.quotient),
    .level_i (sf_level_q),
    .state_o (sf_new)
  );

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_beat) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rate_q <= div_rsp.quotient;
      sd_q   <= sd_new;
      sf_q   <= sf_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign err_rate_o    = rate_q;
  assign degrade_cls_o = sd_q;
  assign fail_cls_o    = sf_q;

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("input taken again straight after a beat");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == bersdf_pkg::ST_RATE_WAIT))
    else $error("divider finished outside the wait state");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bersdf_pkg::ST_DONE))
    else $error("result appeared without a finished item");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the ber degrade/fail monitor: a directed table of samples,
// then random samples across several indicator settings, checked by typed rows or a local predictor
// depends on bersdf_pkg and ber_signal_degrade_fail_monitor_unit

module tb;

  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned NUM_ROWS        = 19;
  localparam int unsigned MAX_PRINTS      = 100;

  typedef struct packed {
    logic [bersdf_pkg::RATE_W-1:0] rate;
    bersdf_pkg::lvl_state_e        sd;
    bersdf_pkg::lvl_state_e        sf;
  } ber_result_t;

  typedef struct packed {
    logic [bersdf_pkg::CNT_W-1:0] cnt;
    logic [bersdf_pkg::CNT_W-1:0] now;
    logic                         typed;   // expected result given in the row itself
    ber_result_t                  res;
  } sample_row_t;

  localparam ber_result_t NO_TYPED = '{58'd0, bersdf_pkg::LVL_OVER, bersdf_pkg::LVL_OVER};

  // decade thresholds in errors per second, indexed by indicator
  localparam longint unsigned DECADE_THR [0:10] = '{
    64'd2488320000, 64'd248832000, 64'd24883200, 64'd2488320, 64'd248832,
    64'd24883, 64'd2488, 64'd248, 64'd24, 64'd2, 64'd1
  };

  // directed samples, starting from reset (degrade 9, fail 5)
  sample_row_t directed_rows [NUM_ROWS] = '{
    // first sample after reset: nothing elapsed, nothing counted
    '{48'd0, 48'd0, 1'b1,
      '{58'd0, bersdf_pkg::LVL_CLEAR, bersdf_pkg::LVL_CLEAR}},
    '{48'd1000, 48'd1000000, 1'b1,
      '{58'd1000, bersdf_pkg::LVL_OVER, bersdf_pkg::LVL_CLEAR}},
    // counter went down: new count taken as it stands
    '{48'd500, 48'd2000000, 1'b1,
      '{58'd500, bersdf_pkg::LVL_OVER, bersdf_pkg::LVL_CLEAR}},
    // under one millisecond: divisor forced to one
    '{48'd600, 48'd2000500, 1'b1,
      '{58'd100000, bersdf_pkg::LVL_OVER, bersdf_pkg::LVL_OVER}},
    // time stepped back: elapsed wraps to nearly 2^48 us
    '{48'd600, 48'd2000000, 1'b1,
      '{58'd0, bersdf_pkg::LVL_CLEAR, bersdf_pkg::LVL_CLEAR}},
    '{48'hFFFF_FFFF_FFFF, 48'd2000000, 1'b0, NO_TYPED},
    '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{58'd0, bersdf_pkg::LVL_CLEAR, bersdf_pkg::LVL_CLEAR}},
    '{48'd0, 48'd0, 1'b1,
      '{58'd0, bersdf_pkg::LVL_CLEAR, bersdf_pkg::LVL_CLEAR}},
    '{48'd1, 48'd1000, 1'b0, NO_TYPED},
    // rate equal to the degrade threshold
    '{48'd3, 48'd1001000, 1'b1,
      '{58'd2, bersdf_pkg::LVL_UNDER, bersdf_pkg::LVL_CLEAR}},
    '{48'd6, 48'd2001000, 1'b0, NO_TYPED},
    // rate equal to the fail threshold, then one above
    '{48'd24889, 48'd3001000, 1'b1,
      '{58'd24883, bersdf_pkg::LVL_OVER, bersdf_pkg::LVL_UNDER}},
    '{48'd49773, 48'd4001000, 1'b0, NO_TYPED},
    // fail clear boundary and one above
    '{48'd52261, 48'd5001000, 1'b0, NO_TYPED},
    '{48'd54750, 48'd6001000, 1'b0, NO_TYPED},
    '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, NO_TYPED},
    '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, NO_TYPED},
    '{48'h5555_5555_5556, 48'hAAAA_AAAA_AE91, 1'b0, NO_TYPED},
    '{48'd0, 48'hFFFF_FFFF_FFFF, 1'b0, NO_TYPED}
  };

  // indicator settings per random phase; the last two are drawn at random
  logic [bersdf_pkg::LVL_W-1:0] phase_sd [NUM_PHASES] =
    '{4'd0, 4'd10, 4'd11, 4'd15, 4'd3, 4'd8, 4'd0, 4'd0};
  logic [bersdf_pkg::LVL_W-1:0] phase_sf [NUM_PHASES] =
    '{4'd10, 4'd0, 4'd15, 4'd11, 4'd6, 4'd2, 4'd0, 4'd0};

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we      = 1'b0;
  bersdf_pkg::cfg_reg_e          cfg_idx     = bersdf_pkg::REG_SD_LEVEL;
  logic [bersdf_pkg::LVL_W-1:0]  cfg_data    = '0;
  logic                          in_valid    = 1'b0;
  logic [bersdf_pkg::CNT_W-1:0]  err_count   = '0;
  logic [bersdf_pkg::CNT_W-1:0]  now_us      = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic [bersdf_pkg::RATE_W-1:0] err_rate;
  logic [1:0]                    degrade_cls;
  logic [1:0]                    fail_cls;

  // predictor state: indicators and the previous sample
  logic [bersdf_pkg::LVL_W-1:0] sd_level_q     = 4'd9;
  logic [bersdf_pkg::LVL_W-1:0] sf_level_q     = 4'd5;
  logic [bersdf_pkg::CNT_W-1:0] prev_err_count = '0;
  logic [bersdf_pkg::CNT_W-1:0] prev_now_us    = '0;

  ber_result_t rate_exp_q [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_asks      = 0;
  logic        quiet          = 1'b0;   // no random idling on either side

  ber_signal_degrade_fail_monitor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .err_count_i   (err_count),
    .now_us_i      (now_us),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .err_rate_o    (err_rate),
    .degrade_cls_o (degrade_cls),
    .fail_cls_o    (fail_cls)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned decade_threshold(
      input logic [bersdf_pkg::LVL_W-1:0] level);
    if (level <= 4'd10) return DECADE_THR[level];
    return DECADE_THR[5];   // out-of-range indicators act as five
  endfunction

  function automatic bersdf_pkg::lvl_state_e rate_class(input longint unsigned rate,
                                                        input longint unsigned thr);
    if (rate > thr) return bersdf_pkg::LVL_OVER;
    if (rate <= thr / 10) return bersdf_pkg::LVL_CLEAR;
    return bersdf_pkg::LVL_UNDER;
  endfunction

  // errors per second for one sample, and the degrade/fail classes; advances the kept sample
  function automatic ber_result_t predict_rate(input logic [bersdf_pkg::CNT_W-1:0] cnt,
                                               input logic [bersdf_pkg::CNT_W-1:0] now);
    longint unsigned              diff;
    longint unsigned              elapsed_ms;
    longint unsigned              rate;
    logic [bersdf_pkg::CNT_W-1:0] elapsed_us;
    ber_result_t                  res;
    if (cnt >= prev_err_count) diff = longint'(cnt - prev_err_count);
    else diff = longint'(cnt);
    elapsed_us = now - prev_now_us;
    elapsed_ms = longint'(elapsed_us) / 1000;
    if (elapsed_ms == 0) elapsed_ms = 1;
    rate = diff * 1000 / elapsed_ms;
    prev_err_count = cnt;
    prev_now_us    = now;
    res.rate = rate[bersdf_pkg::RATE_W-1:0];
    res.sd   = rate_class(rate, decade_threshold(sd_level_q));
    res.sf   = rate_class(rate, decade_threshold(sf_level_q));
    return res;
  endfunction

  // mostly plausible polling intervals with rates near a threshold, plus noise
  task automatic pick_sample(output logic [bersdf_pkg::CNT_W-1:0] cnt,
                             output logic [bersdf_pkg::CNT_W-1:0] now);
    longint unsigned thr;
    longint unsigned target;
    longint unsigned ms;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    thr  = decade_threshold($urandom_range(0, 1) != 0 ? sd_level_q : sf_level_q);
    if (kind < 60) begin
      ms = longint'($urandom_range(1, 3000));
      case ($urandom_range(0, 5))
        0: target = thr;
        1: target = thr + 1;
        2: target = thr / 10;
        3: target = thr / 10 + 1;
        4: target = longint'({$urandom, $urandom}) % (2 * thr + 1);
        default: target = 0;
      endcase
      cnt = prev_err_count + bersdf_pkg::CNT_W'((target * ms + 999) / 1000);
      now = prev_now_us
          + bersdf_pkg::CNT_W'(ms * 1000 + longint'($urandom_range(0, 999)));
    end else if (kind < 75) begin
      // sub-millisecond interval
      cnt = prev_err_count + bersdf_pkg::CNT_W'($urandom_range(0, 5000));
      now = prev_now_us + bersdf_pkg::CNT_W'($urandom_range(0, 999));
    end else if (kind < 92) begin
      cnt = bersdf_pkg::CNT_W'({$urandom, $urandom});
      now = bersdf_pkg::CNT_W'({$urandom, $urandom});
    end else begin
      // counter cleared, or clock stepped back
      cnt = ($urandom_range(0, 1) != 0) ? bersdf_pkg::CNT_W'($urandom_range(0, 1000))
                                        : prev_err_count;
      now = prev_now_us - bersdf_pkg::CNT_W'($urandom_range(0, 5000000));
    end
  endtask

  task automatic set_levels(input logic [bersdf_pkg::LVL_W-1:0] sd,
                            input logic [bersdf_pkg::LVL_W-1:0] sf);
    cfg_we   <= 1'b1;
    cfg_idx  <= bersdf_pkg::REG_SD_LEVEL;
    cfg_data <= sd;
    @(posedge clk_i);
    sd_level_q = sd;
    cfg_idx  <= bersdf_pkg::REG_SF_LEVEL;
    cfg_data <= sf;
    @(posedge clk_i);
    sf_level_q = sf;
    cfg_we   <= 1'b0;
  endtask

  // offer one beat, wait for it to be taken, then queue what it should produce
  task automatic send_sample(input logic [bersdf_pkg::CNT_W-1:0] cnt,
                             input logic [bersdf_pkg::CNT_W-1:0] now,
                             input logic typed, input ber_result_t typed_res);
    ber_result_t want;
    if (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 130)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    err_count <= cnt;
    now_us    <= now;
    do @(posedge clk_i); while (in_stall);
    want = predict_rate(cnt, now);
    if (typed) want = typed_res;
    rate_exp_q.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rate_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    ber_result_t want;
    if (rate_exp_q.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    want = rate_exp_q.pop_front();
    if (err_rate !== want.rate)
      report_mismatch($sformatf("err_rate %0d, expected %0d", err_rate, want.rate));
    if (degrade_cls !== want.sd)
      report_mismatch($sformatf("degrade_cls %0d, expected %0d", degrade_cls, want.sd));
    if (fail_cls !== want.sf)
      report_mismatch($sformatf("fail_cls %0d, expected %0d", fail_cls, want.sf));
  endtask

  // receiver: checks each beat taken, stalls at random or for a long hold-off on request
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_result();
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 14);
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [bersdf_pkg::CNT_W-1:0] cnt;
    logic [bersdf_pkg::CNT_W-1:0] now;
    logic [bersdf_pkg::LVL_W-1:0] sd_set;
    logic [bersdf_pkg::LVL_W-1:0] sf_set;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++)
      send_sample(directed_rows[r].cnt, directed_rows[r].now,
                  directed_rows[r].typed, directed_rows[r].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      sd_set = (p >= 6) ? bersdf_pkg::LVL_W'($urandom_range(0, 15)) : phase_sd[p];
      sf_set = (p >= 6) ? bersdf_pkg::LVL_W'($urandom_range(0, 15)) : phase_sf[p];
      set_levels(sd_set, sf_set);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // phase 2 holds the receiver off while the sender keeps offering; phase 4 runs flat out
        quiet <= (p == 4) || (p == 2 && i >= 20 && i < 40);
        if (p == 2 && i == 20) hold_asks <= hold_asks + 1;
        // sender stops until everything is back
        if (p == 5 && i == 40) drain_results();
        pick_sample(cnt, now);
        send_sample(cnt, now, 1'b0, NO_TYPED);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
